// ===== hw/rtl/tsp_annealing_move_engine_assert.svh =====
// Assertion macros used by the checker of the move engine.
`ifndef TSP_ANNEALING_MOVE_ENGINE_ASSERT_SVH
`define TSP_ANNEALING_MOVE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TAME_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define TAME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tame_pkg.sv =====
package tame_pkg;

  localparam int POS_W   = 6;
  localparam int LOAD_W  = 16;
  localparam int COST_W  = 22;
  localparam int CFG_W   = 7;
  localparam int MODE_W  = 3;

  localparam logic [COST_W-1:0] COST_MAX          = 22'h3FFFFF;
  localparam logic [CFG_W-1:0]  CITY_COUNT_RESET  = 7'd64;

  localparam logic [MODE_W-1:0] MODE_LOAD_TOUR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_DIST = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EVALUATE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REVERSE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position_a;
    logic [POS_W-1:0]  position_b;
    logic [POS_W-1:0]  position_c;
    logic [LOAD_W-1:0] load_value;
    logic [COST_W-1:0] accept_threshold;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [COST_W-1:0] neighbor_cost;
    logic              accepted;
    logic [COST_W-1:0] current_cost;
    logic [COST_W-1:0] best_cost;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic dist_wr;
    logic tour_wr;
    logic build;
    logic cost;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              move_ok;
  } sts_t;

endpackage

// ===== hw/rtl/tame_ctrl.sv =====
module tame_ctrl import tame_pkg::*; #(
  parameter int MAX_CITIES = 64,
  localparam int NW = $clog2(MAX_CITIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sts_t          sts,
  input  logic [NW-1:0] n_val,
  output cmd_t          cmd,
  output logic [NW-1:0] cnt
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DISP  = 3'd1;
  localparam logic [2:0] ST_LOADW = 3'd2;
  localparam logic [2:0] ST_BUILD = 3'd3;
  localparam logic [2:0] ST_COST  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        cnt_nxt = '0;
        case (sts.mode)
          MODE_LOAD_TOUR: state_nxt = ST_LOADW;
          MODE_LOAD_DIST: begin
            cmd.dist_wr = 1'b1;
            state_nxt   = ST_FIN;
          end
          MODE_EVALUATE: state_nxt = ST_COST;
          MODE_REVERSE, MODE_INSERT: state_nxt = sts.move_ok ? ST_BUILD : ST_FIN;
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_LOADW: begin
        cmd.tour_wr = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_BUILD: begin
        cmd.build = 1'b1;
        if (cnt_r == NW'(MAX_CITIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_COST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_COST: begin
        cmd.cost = 1'b1;
        if (cnt_r == n_val) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt_r == NW'(1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign cnt       = cnt_r;

endmodule

// ===== hw/rtl/tame_datapath.sv =====
module tame_datapath import tame_pkg::*; #(
  parameter int MAX_CITIES = 64,
  parameter int DIST_WIDTH = 16,
  localparam int NW = $clog2(MAX_CITIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  in_item_t         in_data,
  input  cmd_t             cmd,
  input  logic [NW-1:0]    cnt,
  output sts_t             sts,
  output logic [NW-1:0]    n_val,
  output out_item_t        out_data
);

  localparam int IW    = $clog2(MAX_CITIES);
  localparam int XW    = ((NW > POS_W) ? NW : POS_W) + 1;
  localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int AW    = $clog2(MAX_CITIES * MAX_CITIES);
  localparam int SW    = ((DIST_WIDTH > COST_W) ? DIST_WIDTH : COST_W) + 1;
  localparam int RECIP = (1 << LOAD_W) / MAX_CITIES;

  logic [CFG_W-1:0]      city_count_r;
  logic [MODE_W-1:0]     mode_r;
  logic [POS_W-1:0]      pa_r, pb_r, pc_r;
  logic [LOAD_W-1:0]     val_r;
  logic [COST_W-1:0]     thr_r;
  logic [LOAD_W-1:0]     q_r;
  logic [IW-1:0]         tour0_mem [MAX_CITIES];
  logic [IW-1:0]         tour1_mem [MAX_CITIES];
  logic [DIST_WIDTH-1:0] dist_mem [MAX_CITIES * MAX_CITIES];
  logic [IW-1:0]         t0_rd_r, t1_rd_r, prev_r, build_k_r;
  logic                  rd_sel_r, cur_sel_r, build_v_r;
  logic                  v1_r, f1_r, v2_r;
  logic [DIST_WIDTH-1:0] dist_rd_r;
  logic [COST_W-1:0]     acc_r, cur_cost_r, best_cost_r;
  out_item_t             out_r, out_nxt;
  logic [COST_W-1:0]     cur_cost_nxt, best_cost_nxt;
  logic                  cur_sel_nxt;

  logic [XW-1:0]   a, b, c, n, k, lo, hi, span, seg, d, rcnt, rsrc, isrc, src;
  logic [XW+1:0]   span3, n2;
  logic            rev_ok, ins_ok, move_ok, tour_pos_ok, dist_pos_ok, cost_cur;
  logic [IW-1:0]   src_idx, cost_idx, rd_idx, tour_rd, city;
  logic [LOAD_W+1:0] rem_w;
  logic [AW-1:0]   dist_waddr, dist_raddr;
  logic [SW-1:0]   sum;
  logic [COST_W-1:0] acc_nxt, diff;
  logic            take;

  // Active city count, clamped into the legal range.
  always_comb begin
    if (city_count_r < CFG_W'(2)) begin
      n_val = NW'(2);
    end else if (CW'(city_count_r) > CW'(MAX_CITIES)) begin
      n_val = NW'(MAX_CITIES);
    end else begin
      n_val = NW'(city_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= CITY_COUNT_RESET;
    end else if (cfg_wr_en) begin
      city_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_data.mode;
      pa_r   <= in_data.position_a;
      pb_r   <= in_data.position_b;
      pc_r   <= in_data.position_c;
      val_r  <= in_data.load_value;
      thr_r  <= in_data.accept_threshold;
    end
    q_r <= LOAD_W'((32'(val_r) * 32'(RECIP)) >> LOAD_W);
  end

  // City number modulo the table size: the reciprocal estimate is at most one low.
  always_comb begin
    rem_w = (LOAD_W + 2)'(val_r) - (LOAD_W + 2)'(q_r) * (LOAD_W + 2)'(MAX_CITIES);
    if (rem_w >= (LOAD_W + 2)'(MAX_CITIES)) begin
      city = IW'(rem_w - (LOAD_W + 2)'(MAX_CITIES));
    end else begin
      city = IW'(rem_w);
    end
  end

  // Move checks and the source position of each candidate slot.
  always_comb begin
    a    = XW'(pa_r);
    b    = XW'(pb_r);
    c    = XW'(pc_r);
    n    = XW'(n_val);
    k    = XW'(cnt);
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    span = hi - lo;
    seg  = span + 1'b1;
    // span > floor(2n/3) holds exactly when 3*span > 2n.
    span3 = (XW + 2)'(span) + (XW + 2)'({span, 1'b0});
    n2    = (XW + 2)'({n, 1'b0});
    rev_ok  = (a < n) && (b < n) && (a != b);
    ins_ok  = rev_ok && (c < n) && !(span3 > n2) && !((c >= lo) && (c <= hi));
    move_ok = (mode_r == MODE_REVERSE) ? rev_ok : ins_ok;

    d    = (k >= a) ? (k - a) : (k + n - a);
    rcnt = (a < b) ? (b - a + 1'b1) : (n - a + b + 1'b1);
    if ((k < n) && (d < rcnt)) begin
      rsrc = (b >= d) ? (b - d) : (b + n - d);
    end else begin
      rsrc = k;
    end

    if (c < lo) begin
      if ((k > c) && (k <= c + seg)) begin
        isrc = lo + k - c - 1'b1;
      end else if ((k > c + seg) && (k <= hi)) begin
        isrc = k - seg;
      end else begin
        isrc = k;
      end
    end else begin
      if ((k >= lo) && (k + seg <= c)) begin
        isrc = k + seg;
      end else if ((k + seg > c) && (k <= c)) begin
        isrc = k + hi - c;
      end else begin
        isrc = k;
      end
    end
    src     = (mode_r == MODE_REVERSE) ? rsrc : isrc;
    src_idx = IW'(src);
  end

  assign tour_pos_ok = XW'(pa_r) < XW'(MAX_CITIES);
  assign dist_pos_ok = tour_pos_ok && (XW'(pb_r) < XW'(MAX_CITIES));
  assign cost_idx    = (XW'(cnt) == n) ? '0 : IW'(cnt);
  assign rd_idx      = cmd.build ? src_idx : cost_idx;
  assign cost_cur    = (mode_r == MODE_EVALUATE);
  assign tour_rd     = rd_sel_r ? t1_rd_r : t0_rd_r;

  // Two tour memories: one holds the current tour, the other the candidate.
  always_ff @(posedge clk) begin
    if ((cmd.tour_wr && tour_pos_ok && !cur_sel_r) || (build_v_r && cur_sel_r)) begin
      tour0_mem[cmd.tour_wr ? IW'(pa_r) : build_k_r] <= cmd.tour_wr ? city : tour_rd;
    end
    t0_rd_r <= tour0_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if ((cmd.tour_wr && tour_pos_ok && cur_sel_r) || (build_v_r && !cur_sel_r)) begin
      tour1_mem[cmd.tour_wr ? IW'(pa_r) : build_k_r] <= cmd.tour_wr ? city : tour_rd;
    end
    t1_rd_r <= tour1_mem[rd_idx];
  end

  assign dist_waddr = AW'(a) * AW'(MAX_CITIES) + AW'(b);
  assign dist_raddr = AW'(prev_r) * AW'(MAX_CITIES) + AW'(tour_rd);

  always_ff @(posedge clk) begin
    if (cmd.dist_wr && dist_pos_ok) begin
      dist_mem[dist_waddr] <= DIST_WIDTH'(val_r);
    end
    dist_rd_r <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    rd_sel_r  <= cmd.build ? cur_sel_r : (cost_cur ? cur_sel_r : ~cur_sel_r);
    build_k_r <= IW'(cnt);
    if (v1_r) begin
      prev_r <= tour_rd;
    end
  end

  assign sum     = SW'(acc_r) + SW'(dist_rd_r);
  assign acc_nxt = (sum > SW'(COST_MAX)) ? COST_MAX : COST_W'(sum);

  always_ff @(posedge clk) begin
    if (cmd.cost && (cnt == '0)) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      build_v_r <= 1'b0;
      v1_r      <= 1'b0;
      f1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      build_v_r <= cmd.build;
      v1_r      <= cmd.cost;
      f1_r      <= (cnt == '0);
      v2_r      <= v1_r && !f1_r;
    end
  end

  // Acceptance and the result transaction.
  assign diff = acc_r - cur_cost_r;
  assign take = (acc_r <= cur_cost_r) || (diff < thr_r);

  always_comb begin
    cur_cost_nxt  = cur_cost_r;
    best_cost_nxt = best_cost_r;
    cur_sel_nxt   = cur_sel_r;
    out_nxt       = '0;
    if (mode_r == MODE_EVALUATE) begin
      cur_cost_nxt          = acc_r;
      best_cost_nxt         = acc_r;
      out_nxt.neighbor_cost = acc_r;
    end else if (mode_r inside {MODE_REVERSE, MODE_INSERT}) begin
      if (!move_ok) begin
        out_nxt.status = 1'b1;
      end else begin
        out_nxt.neighbor_cost = acc_r;
        if (take) begin
          out_nxt.accepted = 1'b1;
          cur_cost_nxt     = acc_r;
          cur_sel_nxt      = ~cur_sel_r;
          if (acc_r < best_cost_r) begin
            best_cost_nxt = acc_r;
          end
        end
      end
    end
    out_nxt.current_cost = cur_cost_nxt;
    out_nxt.best_cost    = best_cost_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cost_r  <= '0;
      best_cost_r <= '0;
      cur_sel_r   <= 1'b0;
    end else if (cmd.commit) begin
      cur_cost_r  <= cur_cost_nxt;
      best_cost_r <= best_cost_nxt;
      cur_sel_r   <= cur_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign sts.mode    = mode_r;
  assign sts.move_ok = move_ok;
  assign out_data    = out_r;

endmodule

// ===== hw/rtl/tsp_annealing_move_engine.sv =====
// Channel   Ports                               Direction  Contents
// in        in_valid, in_ready, in_data         input      one in_item_t per transaction
// out       out_valid, out_ready, out_data      output     one out_item_t per transaction
// cfg       cfg_wr_en, cfg_wr_data              input      city_count, no read-back
//
// One transaction at a time. Loads and rejected moves skip the candidate build and the cost sum.
// Evaluate sums the cost over the N active cities, and a move builds the candidate first;
// the candidate build walks every tour slot once and the cost sum reads one distance per cycle.
// Reset (rst_n low, synchronous) clears the controller, both costs and city_count to 64.
// The tour and distance memories are not cleared and must be loaded before use.
// A result waits in the output register while out_ready is low; the next input is taken
// only after the result of the previous one has been placed in that register.
module tsp_annealing_move_engine import tame_pkg::*; #(
  parameter int MAX_CITIES = 64,
  parameter int DIST_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int NW = $clog2(MAX_CITIES + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [NW-1:0] cnt;
  logic [NW-1:0] n_val;

  // The controller sequences each transaction: dispatch, candidate build,
  // cost sweep, pipeline drain and the final commit into the output register.
  tame_ctrl #(
    .MAX_CITIES(MAX_CITIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .n_val     (n_val),
    .cmd       (cmd),
    .cnt       (cnt)
  );

  // The datapath holds the two tour memories (current and candidate swap roles
  // when a move is accepted), the distance memory, the cost accumulator and
  // the cost registers.
  tame_datapath #(
    .MAX_CITIES(MAX_CITIES),
    .DIST_WIDTH(DIST_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .cnt         (cnt),
    .sts         (sts),
    .n_val       (n_val),
    .out_data    (out_data)
  );

endmodule

// ===== hw/rtl/tame_checker.sv =====
`include "tsp_annealing_move_engine_assert.svh"

module tame_checker import tame_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `TAME_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `TAME_ASSERT_IMPLIES(a_bad_move, out_valid && out_data.status, !out_data.accepted && (out_data.neighbor_cost == '0), "rejected move reports a candidate")
  `TAME_ASSERT_IMPLIES(a_accept_cost, out_valid && out_data.accepted, out_data.current_cost == out_data.neighbor_cost, "accepted cost not adopted")
  `TAME_ASSERT_IMPLIES(a_best_le_cur, out_valid, out_data.best_cost <= out_data.current_cost, "best cost above current cost")

endmodule

bind tsp_annealing_move_engine tame_checker u_tame_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tame_pkg::*;

  // Modes 5 to 7 have no function; the block must answer them with a plain ok result.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int TOUR_SLOTS = 64;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  always #5 clk = ~clk;

  tsp_annealing_move_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow copy of the engine: tour, candidate, distance matrix, both costs and the
  // city count register.
  logic [POS_W-1:0]  shadow_tour [TOUR_SLOTS];
  logic [POS_W-1:0]  shadow_cand [TOUR_SLOTS];
  logic [LOAD_W-1:0] shadow_dist [TOUR_SLOTS][TOUR_SLOTS];
  logic [COST_W-1:0] shadow_current;
  logic [COST_W-1:0] shadow_best;
  logic [CFG_W-1:0]  shadow_city_count;

  out_item_t expected_results[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  // The city count register clamps into the range 2..64.
  function automatic int unsigned cities_active();
    if (shadow_city_count < 2) return 2;
    if (shadow_city_count > TOUR_SLOTS) return TOUR_SLOTS;
    return shadow_city_count;
  endfunction

  // Closed-tour cost of the candidate or the current tour, saturating at the cost ceiling.
  function automatic logic [COST_W-1:0] closed_tour_cost(input bit use_cand, input int unsigned n);
    longint unsigned total;
    logic [POS_W-1:0] from_city, to_city;
    total = 0;
    for (int unsigned i = 0; i < n; i++) begin
      from_city = use_cand ? shadow_cand[i] : shadow_tour[i];
      to_city   = use_cand ? shadow_cand[(i + 1) % n] : shadow_tour[(i + 1) % n];
      total += shadow_dist[from_city][to_city];
      if (total > COST_MAX) total = COST_MAX;
    end
    return total[COST_W-1:0];
  endfunction

  // Reverse the circular span from a to b; the span wraps when a is above b.
  function automatic bit build_reversed(input int unsigned a, input int unsigned b,
                                        input int unsigned n);
    int unsigned span_len;
    logic [POS_W-1:0] held;
    if (a >= n || b >= n || a == b) return 1'b0;
    shadow_cand = shadow_tour;
    span_len = (a < b) ? (b - a + 1) : (n - (a - b) + 1);
    for (int unsigned i = 1; i <= span_len / 2; i++) begin
      held = shadow_cand[a];
      shadow_cand[a] = shadow_cand[b];
      shadow_cand[b] = held;
      a = (a + 1) % n;
      b = (b + n - 1) % n;
    end
    return 1'b1;
  endfunction

  // Lift the segment lo..hi out of the tour and place it right after slot c.
  function automatic bit build_inserted(input int unsigned a, input int unsigned b,
                                        input int unsigned c, input int unsigned n);
    int unsigned lo, hi, slot;
    if (a >= n || b >= n || c >= n || a == b) return 1'b0;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (hi - lo > (n * 2) / 3) return 1'b0;
    if (c >= lo && c <= hi) return 1'b0;
    shadow_cand = shadow_tour;
    slot = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i < lo || i > hi) begin
        shadow_cand[slot++] = shadow_tour[i];
        if (i == c)
          for (int unsigned j = lo; j <= hi; j++) shadow_cand[slot++] = shadow_tour[j];
      end
    end
    return 1'b1;
  endfunction

  // Advance the shadow engine by one transaction and return the result it must produce.
  function automatic out_item_t step_engine(input in_item_t item);
    out_item_t res;
    int unsigned n;
    bit built;
    longint delta;
    res = '0;
    n = cities_active();
    case (item.mode)
      MODE_LOAD_TOUR: shadow_tour[item.position_a] = item.load_value[POS_W-1:0];
      MODE_LOAD_DIST: shadow_dist[item.position_a][item.position_b] = item.load_value;
      MODE_EVALUATE: begin
        res.neighbor_cost = closed_tour_cost(1'b0, n);
        shadow_current = res.neighbor_cost;
        shadow_best = res.neighbor_cost;
      end
      MODE_REVERSE, MODE_INSERT: begin
        if (item.mode == MODE_REVERSE)
          built = build_reversed(item.position_a, item.position_b, n);
        else
          built = build_inserted(item.position_a, item.position_b, item.position_c, n);
        if (!built) begin
          res.status = 1'b1;
        end else begin
          res.neighbor_cost = closed_tour_cost(1'b1, n);
          delta = longint'(res.neighbor_cost) - longint'(shadow_current);
          // A better or equal candidate always wins; a worse one wins below the threshold.
          if (delta <= 0 || delta < longint'(item.accept_threshold)) begin
            res.accepted = 1'b1;
            shadow_tour = shadow_cand;
            shadow_current = res.neighbor_cost;
            if (res.neighbor_cost < shadow_best) shadow_best = res.neighbor_cost;
          end
        end
      end
      default: ;
    endcase
    res.current_cost = shadow_current;
    res.best_cost = shadow_best;
    return res;
  endfunction

  // Result checker: every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result arrived with no expectation pending");
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
          error_count++;
        end
        if (out_data.neighbor_cost !== exp_res.neighbor_cost) begin
          $error("neighbor_cost: expected %0d, got %0d",
                 exp_res.neighbor_cost, out_data.neighbor_cost);
          error_count++;
        end
        if (out_data.accepted !== exp_res.accepted) begin
          $error("accepted: expected %0d, got %0d", exp_res.accepted, out_data.accepted);
          error_count++;
        end
        if (out_data.current_cost !== exp_res.current_cost) begin
          $error("current_cost: expected %0d, got %0d",
                 exp_res.current_cost, out_data.current_cost);
          error_count++;
        end
        if (out_data.best_cost !== exp_res.best_cost) begin
          $error("best_cost: expected %0d, got %0d", exp_res.best_cost, out_data.best_cost);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Send one transaction; the expectation is produced at the edge where it is taken.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    expected_results = {expected_results, step_engine(item)};
  endtask

  // Wait for the block to go idle: no valid offered and every result received.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_city_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_city_count = value;
  endtask

  // Tours only use cities 0..7 and 56..63, so every city bit toggles while only a
  // 16 by 16 corner of the matrix needs loading before any cost is summed.
  function automatic logic [POS_W-1:0] pick_city();
    int unsigned r;
    r = $urandom_range(15);
    return POS_W'((r < 8) ? r : r + 48);
  endfunction

  function automatic logic [LOAD_W-1:0] pick_distance();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'hFFFF;
      2: return LOAD_W'($urandom_range(16'hFFFF));
      default: return LOAD_W'($urandom_range(2000));
    endcase
  endfunction

  function automatic logic [COST_W-1:0] pick_threshold();
    case ($urandom_range(5))
      0: return '0;
      1: return COST_MAX;
      2: return COST_W'($urandom_range(COST_MAX));
      default: return COST_W'($urandom_range(3000));
    endcase
  endfunction

  function automatic in_item_t make_item(input logic [MODE_W-1:0] mode, input int unsigned a,
                                         input int unsigned b, input int unsigned c,
                                         input logic [LOAD_W-1:0] value,
                                         input logic [COST_W-1:0] threshold);
    in_item_t item;
    item.mode = mode;
    item.position_a = POS_W'(a);
    item.position_b = POS_W'(b);
    item.position_c = POS_W'(c);
    item.load_value = value;
    item.accept_threshold = threshold;
    return item;
  endfunction

  // A tour load whose value keeps the city within the loaded corner of the matrix.
  function automatic in_item_t tour_load(input int unsigned slot);
    logic [LOAD_W-1:0] value;
    value = {10'($urandom_range(1023)), pick_city()};
    return make_item(MODE_LOAD_TOUR, slot, $urandom_range(63), $urandom_range(63), value,
                     COST_W'($urandom_range(COST_MAX)));
  endfunction

  // A mostly well-formed move for the active city count, with some noise mixed in.
  function automatic in_item_t random_move(input bit is_insert);
    int unsigned n, lo, hi, c;
    n = cities_active();
    if ($urandom_range(9) == 0)
      return make_item(is_insert ? MODE_INSERT : MODE_REVERSE, $urandom_range(63),
                       $urandom_range(63), $urandom_range(63), LOAD_W'($urandom),
                       pick_threshold());
    if (!is_insert) begin
      lo = $urandom_range(n - 1);
      hi = $urandom_range(n - 1);
      return make_item(MODE_REVERSE, lo, hi, $urandom_range(63), LOAD_W'($urandom),
                       pick_threshold());
    end
    for (int tries = 0; tries < 20; tries++) begin
      lo = $urandom_range(n - 2);
      hi = lo + 1 + $urandom_range((n * 2) / 3 - 1);
      c = $urandom_range(n - 1);
      if (hi < n && (c < lo || c > hi) && (n * 2) / 3 >= 1) begin
        if ($urandom_range(1)) return make_item(MODE_INSERT, hi, lo, c, LOAD_W'($urandom),
                                                pick_threshold());
        return make_item(MODE_INSERT, lo, hi, c, LOAD_W'($urandom), pick_threshold());
      end
    end
    return make_item(MODE_INSERT, $urandom_range(n - 1), $urandom_range(n - 1),
                     $urandom_range(n - 1), LOAD_W'($urandom), pick_threshold());
  endfunction

  // Fill every tour slot and the matrix corner that the tours can reach.
  task automatic test_initial_loads();
    logic [POS_W-1:0] row, col;
    for (int slot = 0; slot < TOUR_SLOTS; slot++) send_item(tour_load(slot));
    for (int r = 0; r < 16; r++)
      for (int k = 0; k < 16; k++) begin
        row = POS_W'((r < 8) ? r : r + 48);
        col = POS_W'((k < 8) ? k : k + 48);
        send_item(make_item(MODE_LOAD_DIST, row, col, $urandom_range(63), pick_distance(),
                            COST_W'($urandom_range(COST_MAX))));
      end
  endtask

  // Short directed list: field extremes, every mode, and each illegal move shape.
  task automatic test_directed();
    write_city_count(7'd64);
    send_item(make_item(MODE_EVALUATE, 0, 0, 0, 16'h0000, '0));
    send_item(make_item(MODE_LOAD_DIST, 63, 63, 63, 16'hFFFF, COST_MAX));
    send_item(make_item(MODE_LOAD_TOUR, 63, 63, 63, 16'hFFFF, COST_MAX));
    send_item(make_item(MODE_EVALUATE, 63, 63, 63, 16'hFFFF, COST_MAX));
    // Reverse: plain span, wrapping span, equal ends, the whole tour.
    send_item(make_item(MODE_REVERSE, 3, 40, 0, '0, '0));
    send_item(make_item(MODE_REVERSE, 60, 2, 0, '0, COST_MAX));
    send_item(make_item(MODE_REVERSE, 9, 9, 0, '0, COST_MAX));
    send_item(make_item(MODE_REVERSE, 0, 63, 0, '0, '0));
    // Insert: descending ends, target before the segment, target inside it,
    // equal ends, and spans just above and at two thirds of the tour.
    send_item(make_item(MODE_INSERT, 20, 10, 40, '0, COST_MAX));
    send_item(make_item(MODE_INSERT, 30, 35, 2, '0, '0));
    send_item(make_item(MODE_INSERT, 10, 20, 15, '0, COST_MAX));
    send_item(make_item(MODE_INSERT, 5, 5, 40, '0, COST_MAX));
    send_item(make_item(MODE_INSERT, 0, 43, 50, '0, COST_MAX));
    send_item(make_item(MODE_INSERT, 0, 42, 63, '0, COST_MAX));
    send_item(make_item(MODE_SPARE_LO, 1, 2, 3, 16'h1234, COST_MAX));
    send_item(make_item(MODE_SPARE_HI, 63, 63, 63, 16'hFFFF, COST_MAX));
    // Small tours: positions past the active count are illegal.
    write_city_count(7'd5);
    send_item(make_item(MODE_EVALUATE, 0, 0, 0, '0, '0));
    send_item(make_item(MODE_REVERSE, 1, 5, 0, '0, COST_MAX));
    send_item(make_item(MODE_INSERT, 0, 1, 4, '0, COST_MAX));
    send_item(make_item(MODE_INSERT, 0, 2, 4, '0, COST_MAX));
    write_city_count(7'd0);
    send_item(make_item(MODE_EVALUATE, 0, 0, 0, '0, '0));
    send_item(make_item(MODE_REVERSE, 1, 0, 0, '0, COST_MAX));
    write_city_count(7'd127);
    send_item(make_item(MODE_EVALUATE, 0, 0, 0, '0, '0));
  endtask

  // Long receiver hold-off while the sender keeps offering, then a full pause.
  task automatic test_backpressure();
    drain();
    hold_cycles = 500;
    for (int i = 0; i < 6; i++) send_item(random_move(i[0]));
    drain();
    send_item(make_item(MODE_EVALUATE, 0, 0, 0, '0, '0));
  endtask

  task automatic test_random(input int item_count);
    in_item_t item;
    int unsigned pick;
    send_item(make_item(MODE_EVALUATE, 0, 0, 0, LOAD_W'($urandom), pick_threshold()));
    for (int i = 0; i < item_count; i++) begin
      pick = $urandom_range(99);
      if (pick < 38)       item = random_move(1'b0);
      else if (pick < 76)  item = random_move(1'b1);
      else if (pick < 84)  item = make_item(MODE_EVALUATE, $urandom_range(63),
                                            $urandom_range(63), $urandom_range(63),
                                            LOAD_W'($urandom), pick_threshold());
      else if (pick < 90)  item = tour_load($urandom_range(63));
      else if (pick < 96)  item = make_item(MODE_LOAD_DIST, $urandom_range(63),
                                            $urandom_range(63), $urandom_range(63),
                                            pick_distance(), pick_threshold());
      else                 item = make_item(MODE_W'($urandom_range(MODE_SPARE_HI,
                                                                   MODE_SPARE_LO)),
                                            $urandom_range(63), $urandom_range(63),
                                            $urandom_range(63), LOAD_W'($urandom),
                                            pick_threshold());
      send_item(item);
    end
  endtask

  initial begin
    shadow_current = '0;
    shadow_best = '0;
    shadow_city_count = CITY_COUNT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First phase: sender idles lightly, receiver stalls often.
    send_idle_pct = 18;
    recv_idle_pct = 46;
    test_initial_loads();
    test_directed();
    test_backpressure();
    write_city_count(7'd64);
    test_random(350);
    write_city_count(7'd3);
    test_random(150);

    // Second phase: the sender is the slow side.
    send_idle_pct = 46;
    recv_idle_pct = 18;
    write_city_count(7'd17);
    test_random(350);
    write_city_count(7'd1);
    test_random(80);
    write_city_count(7'd2);
    test_random(70);

    // Last phase: full throughput on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_city_count(7'd127);
    test_random(300);
    write_city_count(7'd63);
    test_random(150);
    write_city_count(7'd8);
    test_random(150);

    drain();
    repeat (200) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tsp_annealing_move_engine verification clean");
    end else begin
      $display("tsp_annealing_move_engine verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of the whole sequence.
  initial begin
    #40ms;
    $display("tsp_annealing_move_engine verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tame_pkg.sv
hw/rtl/tame_ctrl.sv
hw/rtl/tame_datapath.sv
hw/rtl/tsp_annealing_move_engine.sv
hw/rtl/tame_checker.sv
tb/sv/tb.sv
